/* src/rte_pkg.sv */
// ----------------------------------------------------------------------------
// rte_pkg: shared types and constants for the rate table entry pipeline
// Field widths, register indexes, ATM and time-unit constants, and the widths
// derived from them for the bucket, cell-count and product datapaths.
// ----------------------------------------------------------------------------
`default_nettype none

package rte_pkg;

  // Field widths
  localparam int IDX_W      = 8;
  localparam int SHIFT_W    = 4;
  localparam int BKT_W      = 24;
  localparam int TICK_W     = 32;
  localparam int RATE_W     = 32;
  localparam int MIN_W      = 16;
  localparam int MTU_W      = 16;
  localparam int CSS_W      = 5;
  localparam int TPU_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_RATE      = 3'd0;
  localparam cfg_idx_t REG_MIN_UNIT  = 3'd1;
  localparam cfg_idx_t REG_LINK_TYPE = 3'd2;
  localparam cfg_idx_t REG_MTU       = 3'd3;
  localparam cfg_idx_t REG_SHIFT     = 3'd4;
  localparam cfg_idx_t REG_TPU       = 3'd5;

  // Reset values
  localparam logic [RATE_W-1:0] RATE_RESET  = 32'd125000;
  localparam logic [CSS_W-1:0]  SHIFT_RESET = 5'h1F;
  localparam logic [TPU_W-1:0]  TPU_RESET   = 8'd1;

  // Auto shift: zero MTU counts as 2047, shift until MTU fits in 8 bits
  localparam logic [MTU_W-1:0] MTU_DEFAULT  = 16'd2047;
  localparam int               MTU_FIT_BITS = 8;

  // Scheme constants
  localparam longint unsigned TIME_UNITS        = 64'd1000000;
  localparam longint unsigned ATM_PAYLOAD_BYTES = 64'd48;
  localparam longint unsigned ATM_CELL_BYTES    = 64'd53;

  // Ceiling divide by the payload size: floor((sz + PAY - 1) * M >> K)
  localparam int              ATM_N_W = BKT_W + 1;
  localparam int              ATM_L   = $clog2(ATM_PAYLOAD_BYTES);
  localparam int              ATM_K   = ATM_N_W + ATM_L;
  localparam int              ATM_M_W = ATM_N_W + 1;
  localparam int              ATM_P_W = ATM_N_W + ATM_M_W;
  localparam longint unsigned ATM_M   =
    ((64'd1 << ATM_K) + ATM_PAYLOAD_BYTES - 64'd1) / ATM_PAYLOAD_BYTES;

  // Size ranges
  localparam longint unsigned RAW_MAX   = (64'd1 << BKT_W) - 64'd1;
  localparam longint unsigned CELLS_MAX =
    (RAW_MAX + ATM_PAYLOAD_BYTES - 64'd1) / ATM_PAYLOAD_BYTES;
  localparam longint unsigned ATM_MAX   = CELLS_MAX * ATM_CELL_BYTES;
  localparam int CELLS_W = $clog2(CELLS_MAX + 64'd1);
  localparam int SIZE_W  = (ATM_MAX > RAW_MAX) ? $clog2(ATM_MAX + 64'd1) : BKT_W;

  // Product and divider widths
  localparam int TU_W      = $clog2(TIME_UNITS + 64'd1);
  localparam int PROD_W    = SIZE_W + TU_W;
  localparam int HI_W      = PROD_W - TICK_W;
  localparam int DIV_STEPS = TICK_W;
  localparam int MUL_W     = TICK_W + TPU_W;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [RATE_W-1:0] rate;
    logic [MIN_W-1:0]  min_unit;
    logic              link_atm;
    logic [MTU_W-1:0]  mtu;
    logic [CSS_W-1:0]  shift_set;
    logic [TPU_W-1:0]  tpu;
  } rte_cfg_t;

  // Per-beat sideband carried alongside the divide
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [SHIFT_W-1:0] shift;
    logic [BKT_W-1:0]   bucket;
  } rte_side_t;

  // Finished result
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [TICK_W-1:0]  ticks;
    logic [BKT_W-1:0]   bucket;
    logic [SHIFT_W-1:0] shift;
    logic               sat;
    logic               rz;
  } rte_res_t;

endpackage

`default_nettype wire

/* src/rte_front.sv */
// ----------------------------------------------------------------------------
// rte_front: bucket size and byte-time product
// Five stages: shift select and bucket shift, minimum raise, ATM cell count,
// ATM cell bytes, multiply by the time unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_front import rte_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [IDX_W-1:0] entry_index,
  input  rte_cfg_t         cfg,
  output logic             prod_valid,
  output logic [PROD_W-1:0] prod,
  output rte_side_t        side
);

  // Stage 1 logic: pick the shift, shift index+1
  logic [MTU_W-1:0]   mtu_eff;
  logic [SHIFT_W-1:0] auto_shift;
  logic [SHIFT_W-1:0] shift_sel;
  logic [IDX_W:0]     idx_p1;
  logic [BKT_W-1:0]   raw0;

  always_comb begin
    mtu_eff    = (cfg.mtu == '0) ? MTU_DEFAULT : cfg.mtu;
    auto_shift = '0;
    // highest set bit above the 8-bit window sets the shift
    for (int b = MTU_FIT_BITS; b < MTU_W; b++) begin
      if (mtu_eff[b]) auto_shift = SHIFT_W'(b - MTU_FIT_BITS + 1);
    end
    shift_sel = cfg.shift_set[CSS_W-1] ? auto_shift : cfg.shift_set[SHIFT_W-1:0];
    idx_p1    = {1'b0, entry_index} + (IDX_W+1)'(1);
    raw0      = BKT_W'(idx_p1) << shift_sel;
  end

  logic               s1_vld, s2_vld, s3_vld, s4_vld, s5_vld;
  logic [IDX_W-1:0]   s1_idx, s2_idx, s3_idx;
  logic [SHIFT_W-1:0] s1_shift, s2_shift, s3_shift;
  logic [BKT_W-1:0]   s1_raw, s2_sz, s3_sz;
  logic [ATM_N_W-1:0] s2_n;
  logic [CELLS_W-1:0] s3_cells;
  logic [SIZE_W-1:0]  s4_size;
  rte_side_t          s4_side, s5_side;
  logic [PROD_W-1:0]  s5_prod;

  // Stage 2 logic: raise to minimum, bias for ceiling divide
  logic [BKT_W-1:0]   sz_min;
  logic [ATM_N_W-1:0] n_ceil;

  always_comb begin
    sz_min = (s1_raw < BKT_W'(cfg.min_unit)) ? BKT_W'(cfg.min_unit) : s1_raw;
    n_ceil = ATM_N_W'(sz_min) + ATM_N_W'(ATM_PAYLOAD_BYTES - 64'd1);
  end

  // Stage 3 logic: reciprocal multiply gives the cell count
  logic [ATM_P_W-1:0] recip_prod;
  logic [CELLS_W-1:0] cells;

  assign recip_prod = ATM_P_W'(s2_n) * ATM_P_W'(ATM_M);
  assign cells      = recip_prod[ATM_K +: CELLS_W];

  // Stage 4 logic: cell bytes on ATM, clamp the reported bucket
  logic [SIZE_W-1:0] size_sel;
  logic [BKT_W-1:0]  bucket_sat;

  always_comb begin
    size_sel   = cfg.link_atm ? SIZE_W'(s3_cells) * SIZE_W'(ATM_CELL_BYTES)
                              : SIZE_W'(s3_sz);
    bucket_sat = (size_sel > SIZE_W'(RAW_MAX)) ? '1 : BKT_W'(size_sel);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      s1_idx   <= entry_index;
      s1_shift <= shift_sel;
      s1_raw   <= raw0;

      s2_idx   <= s1_idx;
      s2_shift <= s1_shift;
      s2_sz    <= sz_min;
      s2_n     <= n_ceil;

      s3_idx   <= s2_idx;
      s3_shift <= s2_shift;
      s3_sz    <= s2_sz;
      s3_cells <= cells;

      s4_size        <= size_sel;
      s4_side.idx    <= s3_idx;
      s4_side.shift  <= s3_shift;
      s4_side.bucket <= bucket_sat;

      s5_prod <= PROD_W'(s4_size) * PROD_W'(TIME_UNITS);
      s5_side <= s4_side;
    end
  end

  assign prod_valid = s5_vld;
  assign prod       = s5_prod;
  assign side       = s5_side;

endmodule

`default_nettype wire

/* src/rte_div.sv */
// ----------------------------------------------------------------------------
// rte_div: pipelined restoring divide of the byte-time product by the rate
// One entry stage checks for quotient overflow, then one quotient bit per
// stage for the 32 low quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_div import rte_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [PROD_W-1:0] prod,
  input  rte_side_t         side_in,
  input  logic [RATE_W-1:0] rate,
  output logic              out_valid,
  output logic [TICK_W-1:0] quot,
  output logic              sat_pre,
  output rte_side_t         side_out
);

  logic              vld  [0:DIV_STEPS];
  logic [RATE_W-1:0] rem  [0:DIV_STEPS];
  logic [TICK_W-1:0] word [0:DIV_STEPS];
  logic              sat  [0:DIV_STEPS];
  rte_side_t         sd   [0:DIV_STEPS];

  logic [RATE_W-1:0] rem_next  [0:DIV_STEPS-1];
  logic [TICK_W-1:0] word_next [0:DIV_STEPS-1];

  // Upper product bits start the remainder; at or above rate means q >= 2^32
  logic [RATE_W-1:0] prod_hi;
  assign prod_hi = RATE_W'(prod[PROD_W-1:TICK_W]);

  // One quotient bit per stage
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [RATE_W:0] r2;
    logic [RATE_W:0] diff;
    logic            ge;

    assign r2           = {rem[i], word[i][TICK_W-1]};
    assign diff         = r2 - {1'b0, rate};
    assign ge           = (r2 >= {1'b0, rate});
    assign rem_next[i]  = ge ? diff[RATE_W-1:0] : r2[RATE_W-1:0];
    assign word_next[i] = {word[i][TICK_W-2:0], ge};
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 0; i < DIV_STEPS; i++) begin
        vld[i+1] <= vld[i];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= prod_hi;
      word[0] <= prod[TICK_W-1:0];
      sat[0]  <= (prod_hi >= rate);
      sd[0]   <= side_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem[i+1]  <= rem_next[i];
        word[i+1] <= word_next[i];
        sat[i+1]  <= sat[i];
        sd[i+1]   <= sd[i];
      end
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign quot      = word[DIV_STEPS];
  assign sat_pre   = sat[DIV_STEPS];
  assign side_out  = sd[DIV_STEPS];

endmodule

`default_nettype wire

/* src/rte_tail.sv */
// ----------------------------------------------------------------------------
// rte_tail: tick scaling, saturation and output buffering
// Multiplies the quotient by ticks per microsecond, applies the saturation
// and zero-rate rules, and holds results in an output register plus skid.
// ----------------------------------------------------------------------------
`default_nettype none

module rte_tail import rte_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [TICK_W-1:0]  quot,
  input  logic               sat_pre,
  input  rte_side_t          side,
  input  rte_cfg_t           cfg,
  output logic               en,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [IDX_W-1:0]   index_out,
  output logic [TICK_W-1:0]  xmit_ticks,
  output logic [BKT_W-1:0]   bucket_bytes,
  output logic [SHIFT_W-1:0] shift_used,
  output logic               saturated,
  output logic               rate_zero
);

  logic             t_vld;
  logic [MUL_W-1:0] t_mul;
  logic             t_sat;
  rte_side_t        t_side;

  logic     out_vld, skid_vld;
  rte_res_t out_res, skid_res, fin;
  logic     arr, free;

  // Pipeline advances unless the skid holds a beat
  assign en   = !skid_vld;
  assign arr  = en && t_vld;
  assign free = !out_vld || !out_stall;

  // Final result from the scaled quotient
  always_comb begin
    fin.idx    = t_side.idx;
    fin.bucket = t_side.bucket;
    fin.shift  = t_side.shift;
    fin.rz     = (cfg.rate == '0);
    fin.sat    = 1'b0;
    fin.ticks  = t_mul[TICK_W-1:0];
    if (fin.rz) begin
      fin.ticks = '1;
    end else if (cfg.tpu == '0) begin
      fin.ticks = '0;
    end else if (t_sat || (t_mul[MUL_W-1:TICK_W] != '0)) begin
      fin.ticks = '1;
      fin.sat   = 1'b1;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld    <= 1'b0;
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (en) t_vld <= in_valid;
      if (free) begin
        if (skid_vld) begin
          out_vld  <= 1'b1;
          skid_vld <= 1'b0;
        end else begin
          out_vld <= arr;
        end
      end else if (arr) begin
        skid_vld <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (en) begin
      t_mul  <= MUL_W'(quot) * MUL_W'(cfg.tpu);
      t_sat  <= sat_pre;
      t_side <= side;
    end
    if (free) begin
      out_res <= skid_vld ? skid_res : fin;
    end else if (arr) begin
      skid_res <= fin;
    end
  end

  assign out_valid    = out_vld;
  assign index_out    = out_res.idx;
  assign xmit_ticks   = out_res.ticks;
  assign bucket_bytes = out_res.bucket;
  assign shift_used   = out_res.shift;
  assign saturated    = out_res.sat;
  assign rate_zero    = out_res.rz;

endmodule

`default_nettype wire

/* src/rate_table_entry_top.sv */
// ----------------------------------------------------------------------------
// rate_table_entry_top: traffic-shaper rate table entry calculator
// Takes an entry index, returns bucket size and transmit time in ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: entry_index with in_valid / in_stall. Output channel:
//   index_out, xmit_ticks, bucket_bytes, shift_used, saturated, rate_zero
//   with out_valid / out_stall. A beat moves when valid is high and stall low.
//   Configuration is written through cfg_write / cfg_index / cfg_data while
//   no beats are in flight; writes to unused indexes are ignored.
//   Throughput: one beat per cycle while in_stall is low. A result passes
//   through five stages for bucket and product, 33 for the divider (overflow
//   check plus one quotient bit per stage of the 32-bit restoring divide), one
//   for tick scaling and one for the output register.
//   Stall: results wait in the output register and the pipeline keeps moving
//   until one more result lands in the skid register; in_stall then rises
//   and the whole pipeline holds until the skid drains.
//   Reset: synchronous, clears all valid bits and loads register defaults
//   (125000 B/s, automatic shift, Ethernet, one tick per microsecond).
// ----------------------------------------------------------------------------
`default_nettype none

module rate_table_entry_top import rte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [IDX_W-1:0]      entry_index,
  // output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [IDX_W-1:0]      index_out,
  output logic [TICK_W-1:0]     xmit_ticks,
  output logic [BKT_W-1:0]      bucket_bytes,
  output logic [SHIFT_W-1:0]    shift_used,
  output logic                  saturated,
  output logic                  rate_zero
);

  rte_cfg_t cfg;
  logic     adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate      <= RATE_RESET;
      cfg.min_unit  <= '0;
      cfg.link_atm  <= 1'b0;
      cfg.mtu       <= '0;
      cfg.shift_set <= SHIFT_RESET;
      cfg.tpu       <= TPU_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RATE:      cfg.rate      <= cfg_data[RATE_W-1:0];
        REG_MIN_UNIT:  cfg.min_unit  <= cfg_data[MIN_W-1:0];
        REG_LINK_TYPE: cfg.link_atm  <= cfg_data[0];
        REG_MTU:       cfg.mtu       <= cfg_data[MTU_W-1:0];
        REG_SHIFT:     cfg.shift_set <= cfg_data[CSS_W-1:0];
        REG_TPU:       cfg.tpu       <= cfg_data[TPU_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !adv;

  // Bucket and product
  logic              prod_valid;
  logic [PROD_W-1:0] prod;
  rte_side_t         front_side;

  rte_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (in_valid),
    .entry_index (entry_index),
    .cfg         (cfg),
    .prod_valid  (prod_valid),
    .prod        (prod),
    .side        (front_side)
  );

  // Divide by rate
  logic              div_valid;
  logic [TICK_W-1:0] quot;
  logic              sat_pre;
  rte_side_t         div_side;

  rte_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (prod_valid),
    .prod      (prod),
    .side_in   (front_side),
    .rate      (cfg.rate),
    .out_valid (div_valid),
    .quot      (quot),
    .sat_pre   (sat_pre),
    .side_out  (div_side)
  );

  // Scale, saturate, buffer
  rte_tail u_tail (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (div_valid),
    .quot         (quot),
    .sat_pre      (sat_pre),
    .side         (div_side),
    .cfg          (cfg),
    .en           (adv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .index_out    (index_out),
    .xmit_ticks   (xmit_ticks),
    .bucket_bytes (bucket_bytes),
    .shift_used   (shift_used),
    .saturated    (saturated),
    .rate_zero    (rate_zero)
  );

`ifndef SYNTHESIS
  // Skid only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid full with empty output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall rose without an output stall");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(saturated && rate_zero))
    else $error("saturated and rate_zero both set");

  a_flag_ticks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (saturated || rate_zero)) |-> (xmit_ticks == '1))
    else $error("flagged result without maximum ticks");
`endif

endmodule

`default_nettype wire

/* tb/rate_table_entry_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rate_table_entry_top_test: self-checking bench for the rate table entry block
// A short table of directed entries, some with hand-computed results, then
// random phases. Each phase uses its own shaper setting: rate, minimum unit,
// link type, MTU, cell shift and tick multiplier. Every accepted beat is
// checked field by field against its typed-in result or a local predictor,
// with random idling on both channels outside the steady phase.
// ----------------------------------------------------------------------------

module rate_table_entry_top_test;
  import rte_pkg::*;

  localparam int              PIPE_LATENCY   = 39;
  localparam int              QUIET_LIMIT    = 5000;
  localparam int              RANDOM_ITEMS   = 750;
  localparam int              IDLE_PERCENT   = 19;
  localparam int              NUM_PROBES     = 20;
  localparam longint unsigned TICK_MAX       = 64'hFFFF_FFFF;
  localparam longint unsigned BUCKET_MAX     = 64'hFF_FFFF;
  localparam cfg_idx_t        REG_UNUSED     = 3'd6;
  localparam logic [CSS_W-1:0] SHIFT_AUTO_LOW = 5'h10;

  localparam rte_cfg_t RESET_CFG = '{RATE_RESET, 16'd0, 1'b0, 16'd0, SHIFT_RESET, TPU_RESET};

  // One directed entry: setting, index, and a typed-in result when trusted
  typedef struct packed {
    rte_cfg_t          cfg;
    logic [IDX_W-1:0]  idx;
    logic              typed_in;
    rte_res_t          res;
  } probe_row_t;

  localparam probe_row_t PROBES [NUM_PROBES] = '{
    // reset setting: auto shift 3, 8 us per byte
    '{RESET_CFG, 8'd0, 1'b1, '{8'd0, 32'd64, 24'd8, 4'd3, 1'b0, 1'b0}},
    '{RESET_CFG, 8'd255, 1'b1, '{8'd255, 32'd16384, 24'd2048, 4'd3, 1'b0, 1'b0}},
    // zero rate
    '{'{32'd0, 16'd0, 1'b0, 16'd0, SHIFT_RESET, 8'd1}, 8'd7, 1'b1,
      '{8'd7, 32'hFFFF_FFFF, 24'd64, 4'd3, 1'b0, 1'b1}},
    // slowest rate, largest bucket: quotient overflow
    '{'{32'd1, 16'd0, 1'b0, 16'd0, 5'd15, 8'd255}, 8'd255, 1'b1,
      '{8'd255, 32'hFFFF_FFFF, 24'h80_0000, 4'd15, 1'b1, 1'b0}},
    // fastest rate, smallest bucket
    '{'{32'hFFFF_FFFF, 16'd0, 1'b0, 16'd0, 5'd0, 8'd1}, 8'd0, 1'b1,
      '{8'd0, 32'd0, 24'd1, 4'd0, 1'b0, 1'b0}},
    // zero tick multiplier
    '{'{32'd125000, 16'd0, 1'b0, 16'd0, 5'd0, 8'd0}, 8'd100, 1'b1,
      '{8'd100, 32'd0, 24'd101, 4'd0, 1'b0, 1'b0}},
    // ATM cell rounding around one payload
    '{'{32'd125000, 16'd0, 1'b1, 16'd0, 5'd0, 8'd1}, 8'd0, 1'b1,
      '{8'd0, 32'd424, 24'd53, 4'd0, 1'b0, 1'b0}},
    '{'{32'd125000, 16'd0, 1'b1, 16'd0, 5'd0, 8'd1}, 8'd47, 1'b1,
      '{8'd47, 32'd424, 24'd53, 4'd0, 1'b0, 1'b0}},
    '{'{32'd125000, 16'd0, 1'b1, 16'd0, 5'd0, 8'd1}, 8'd48, 1'b1,
      '{8'd48, 32'd848, 24'd106, 4'd0, 1'b0, 1'b0}},
    // largest minimum unit
    '{'{32'd125000, 16'hFFFF, 1'b0, 16'd0, 5'd0, 8'd1}, 8'd5, 1'b1,
      '{8'd5, 32'd524280, 24'd65535, 4'd0, 1'b0, 1'b0}},
    // the rest go through the predictor
    '{'{32'd125000, 16'hFFFF, 1'b1, 16'd0, 5'd0, 8'd1}, 8'd5, 1'b0, '0},
    '{'{32'd125000, 16'd0, 1'b0, 16'hFFFF, SHIFT_AUTO_LOW, 8'd1}, 8'd200, 1'b0, '0},
    '{'{32'd125000, 16'd0, 1'b0, 16'd255, SHIFT_RESET, 8'd1}, 8'd255, 1'b0, '0},
    '{'{32'd125000, 16'd0, 1'b0, 16'd256, SHIFT_RESET, 8'd1}, 8'd128, 1'b0, '0},
    '{'{32'd125000, 16'd0, 1'b0, 16'd1, SHIFT_RESET, 8'd1}, 8'd1, 1'b0, '0},
    '{'{32'd125000, 16'd0, 1'b0, 16'd0, 5'd15, 8'd255}, 8'd255, 1'b0, '0},
    '{'{32'd125000, 16'd0, 1'b0, 16'd0, 5'd0, 8'd255}, 8'd3, 1'b0, '0},
    '{'{32'd1, 16'd0, 1'b1, 16'd0, 5'd15, 8'd1}, 8'd255, 1'b0, '0},
    '{'{32'd125000, 16'd0, 1'b0, 16'd4096, 5'h17, 8'd1}, 8'd60, 1'b0, '0},
    '{'{32'd3, 16'd100, 1'b1, 16'd0, 5'd2, 8'd7}, 8'd9, 1'b0, '0}
  };

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [IDX_W-1:0]      entry_index  = '0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [IDX_W-1:0]      index_out;
  logic [TICK_W-1:0]     xmit_ticks;
  logic [BKT_W-1:0]      bucket_bytes;
  logic [SHIFT_W-1:0]    shift_used;
  logic                  saturated;
  logic                  rate_zero;

  rte_cfg_t shaper_cfg      = RESET_CFG;
  rte_res_t pending_entries [$];
  bit       steady          = 1'b0;
  int       mismatch_count  = 0;
  int       quiet_cycles    = 0;

  rate_table_entry_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .entry_index  (entry_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .index_out    (index_out),
    .xmit_ticks   (xmit_ticks),
    .bucket_bytes (bucket_bytes),
    .shift_used   (shift_used),
    .saturated    (saturated),
    .rate_zero    (rate_zero)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Expected entry for one index under a given shaper setting
  function automatic rte_res_t compute_entry(input rte_cfg_t c, input logic [IDX_W-1:0] idx);
    rte_res_t           r;
    logic [SHIFT_W-1:0] sh;
    logic [MTU_W-1:0]   mtu;
    longint unsigned    sz;
    longint unsigned    q;
    longint unsigned    t;
    sh = c.shift_set[SHIFT_W-1:0];
    // negative setting: smallest shift that brings the MTU to 8 bits
    if (c.shift_set[CSS_W-1]) begin
      mtu = (c.mtu == '0) ? MTU_DEFAULT : c.mtu;
      sh  = '0;
      while ((mtu >> sh) > 255 && sh < 15) sh++;
    end
    sz = (64'(idx) + 64'd1) << sh;
    if (sz < 64'(c.min_unit)) sz = 64'(c.min_unit);
    if (c.link_atm) sz = ((sz + ATM_PAYLOAD_BYTES - 64'd1) / ATM_PAYLOAD_BYTES) * ATM_CELL_BYTES;
    r.idx    = idx;
    r.shift  = sh;
    r.bucket = (sz > BUCKET_MAX) ? BKT_W'(BUCKET_MAX) : sz[BKT_W-1:0];
    r.sat    = 1'b0;
    r.rz     = 1'b0;
    if (c.rate == '0) begin
      r.rz    = 1'b1;
      r.ticks = '1;
    end else begin
      q = (sz * TIME_UNITS) / 64'(c.rate);
      t = q * 64'(c.tpu);
      if (c.tpu == '0) begin
        r.ticks = '0;
      end else if (q > TICK_MAX || t > TICK_MAX) begin
        r.sat   = 1'b1;
        r.ticks = '1;
      end else begin
        r.ticks = t[TICK_W-1:0];
      end
    end
    return r;
  endfunction

  // Random setting, leaning on the extremes of each register
  function automatic rte_cfg_t pick_setting();
    rte_cfg_t c;
    case ($urandom_range(9))
      0:       c.rate = '0;
      1:       c.rate = 32'd1;
      2:       c.rate = '1;
      3:       c.rate = RATE_RESET;
      4, 5, 6: c.rate = $urandom_range(1000, 10000000);
      default: c.rate = $urandom;
    endcase
    case ($urandom_range(4))
      0, 1:    c.min_unit = '0;
      2:       c.min_unit = '1;
      3:       c.min_unit = MIN_W'($urandom_range(2000));
      default: c.min_unit = MIN_W'($urandom);
    endcase
    c.link_atm = 1'($urandom_range(1));
    case ($urandom_range(3))
      0:       c.mtu = '0;
      1:       c.mtu = '1;
      2:       c.mtu = MTU_W'($urandom_range(600));
      default: c.mtu = MTU_W'($urandom);
    endcase
    case ($urandom_range(5))
      0:       c.shift_set = SHIFT_RESET;
      1:       c.shift_set = SHIFT_AUTO_LOW;
      2:       c.shift_set = {1'b1, 4'($urandom)};
      3:       c.shift_set = 5'd0;
      4:       c.shift_set = 5'd15;
      default: c.shift_set = {1'b0, 4'($urandom)};
    endcase
    case ($urandom_range(5))
      0:       c.tpu = '0;
      1:       c.tpu = 8'd1;
      2:       c.tpu = '1;
      default: c.tpu = TPU_W'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return IDX_W'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_index(input logic [IDX_W-1:0] idx, input rte_res_t want);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    entry_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_entries.push_back(want);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected entry is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write all six registers, optionally with a stray write to an unused index
  task automatic apply_setting(input rte_cfg_t c, input bit with_stray);
    cfg_write <= 1'b1;
    if (with_stray) begin
      cfg_index <= REG_UNUSED;
      cfg_data  <= $urandom;
      @(negedge clk);
    end
    cfg_index <= REG_RATE;
    cfg_data  <= c.rate;
    @(negedge clk);
    cfg_index <= REG_MIN_UNIT;
    cfg_data  <= CFG_DATA_W'(c.min_unit);
    @(negedge clk);
    cfg_index <= REG_LINK_TYPE;
    cfg_data  <= CFG_DATA_W'(c.link_atm);
    @(negedge clk);
    cfg_index <= REG_MTU;
    cfg_data  <= CFG_DATA_W'(c.mtu);
    @(negedge clk);
    cfg_index <= REG_SHIFT;
    cfg_data  <= {{(CFG_DATA_W-CSS_W){c.shift_set[CSS_W-1]}}, c.shift_set};
    @(negedge clk);
    cfg_index <= REG_TPU;
    cfg_data  <= CFG_DATA_W'(c.tpu);
    @(negedge clk);
    cfg_write  <= 1'b0;
    shaper_cfg  = c;
  endtask

  // Receiver stalls at random except in the steady stretch
  always @(negedge clk) begin
    out_stall <= !rst && !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Result checker
  always @(posedge clk) begin
    rte_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) begin
        $error("result beat with nothing expected: index_out %0d", index_out);
        mismatch_count++;
      end else begin
        e = pending_entries.pop_front();
        if (index_out !== e.idx) begin
          $error("index_out: expected %0d, got %0d", e.idx, index_out);
          mismatch_count++;
        end
        if (xmit_ticks !== e.ticks) begin
          $error("xmit_ticks: expected %0d, got %0d", e.ticks, xmit_ticks);
          mismatch_count++;
        end
        if (bucket_bytes !== e.bucket) begin
          $error("bucket_bytes: expected %0d, got %0d", e.bucket, bucket_bytes);
          mismatch_count++;
        end
        if (shift_used !== e.shift) begin
          $error("shift_used: expected %0d, got %0d", e.shift, shift_used);
          mismatch_count++;
        end
        if (saturated !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, saturated);
          mismatch_count++;
        end
        if (rate_zero !== e.rz) begin
          $error("rate_zero: expected %0d, got %0d", e.rz, rate_zero);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rate_table_entry_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int               phase;
    int               beats;
    int               sent_random;
    int               k;
    probe_row_t       row;
    logic [IDX_W-1:0] idx_pick;
    phase       = 0;
    sent_random = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed entries, new setting only when the table row changes it
    for (k = 0; k < NUM_PROBES; k++) begin
      row = PROBES[k];
      if (row.cfg != shaper_cfg) begin
        wait_drained();
        apply_setting(row.cfg, 1'b0);
      end
      send_index(row.idx, row.typed_in ? row.res : compute_entry(row.cfg, row.idx));
    end

    // random phases, one setting each; phase 2 runs without idling
    while (sent_random < RANDOM_ITEMS) begin
      wait_drained();
      apply_setting(pick_setting(), phase == 0);
      steady = (phase == 2);
      beats  = $urandom_range(40, 80);
      for (k = 0; k < beats; k++) begin
        if (phase == 1 && k == beats / 2) wait_drained();
        idx_pick = pick_index();
        send_index(idx_pick, compute_entry(shaper_cfg, idx_pick));
      end
      sent_random += beats;
      phase++;
    end
    steady = 1'b0;

    // drain, then watch for stray beats
    wait_drained();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_entries.size() == 0) begin
      $display("rate_table_entry_top verification clean");
    end else begin
      $display("rate_table_entry_top verification failed");
    end
    $finish;
  end

endmodule
